### hdl/ldfs_pkg.sv
// Shared constants and types for the LED driver frame serializer.
// No dependencies; imported by ldfs_store, led_driver_frame_serializer and the testbench.
package ldfs_pkg;

  localparam int FRAME_BYTES_DEF = 96;
  localparam int BYTE_W          = 8;
  localparam int INDEX_W         = 7;
  localparam int KIND_W          = 2;

  typedef enum logic [KIND_W-1:0] {
    KIND_LOAD  = 2'd0,
    KIND_START = 2'd1,
    KIND_TICK  = 2'd2
  } kind_t;

endpackage

### hdl/led_driver_frame_serializer.sv
// LED driver frame serializer: an accepted word's result appears in the next cycle. Throughput
// is one word per cycle unless stalled; each shift tick moves one frame bit out of an 8-bit
// shift register, refilled from the frame store's registered read port once every eight ticks.
// Reset (rst, synchronous, active high) clears the frame state and the output valid flag;
// the frame store itself is not cleared and holds garbage until loaded.
// Depends on ldfs_pkg and ldfs_store.
module led_driver_frame_serializer #(
  parameter int FRAME_BYTES = ldfs_pkg::FRAME_BYTES_DEF
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic [ldfs_pkg::KIND_W-1:0]  kind,
  input  logic [ldfs_pkg::INDEX_W-1:0] byte_index,
  input  logic [ldfs_pkg::BYTE_W-1:0]  byte_value,
  input  logic                         control_frame,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic                         serial_bit,
  output logic                         bit_valid,
  output logic                         last_bit,
  output logic                         latch_pulse,
  output logic                         busy_res
);
  import ldfs_pkg::*;

  localparam int ADDR_W   = $clog2(FRAME_BYTES);
  localparam int SLOT_W   = $clog2(FRAME_BYTES + 1);
  localparam int POS_W    = $clog2(FRAME_BYTES * 8 + 1);
  localparam logic [POS_W-1:0]  LAST_POS  = POS_W'(FRAME_BYTES * 8);
  localparam logic [SLOT_W-1:0] TOP_SLOT  = SLOT_W'(FRAME_BYTES - 1);
  localparam logic [SLOT_W-1:0] HALF_SLOT = SLOT_W'(FRAME_BYTES / 2);
  localparam logic [SLOT_W-1:0] END_SLOT  = SLOT_W'(FRAME_BYTES);
  localparam logic [ADDR_W-1:0] HALF_TOP  = ADDR_W'(FRAME_BYTES / 2 - 1);
  localparam logic [INDEX_W:0]  INDEX_END = (INDEX_W + 1)'(FRAME_BYTES);

  logic                sending, sending_next;
  logic                latch_pending, latch_pending_next;
  logic                frame_is_control, frame_is_control_next;
  logic [POS_W-1:0]    pos, pos_next;
  logic [SLOT_W-1:0]   next_slot, next_slot_next;
  logic [BYTE_W-1:0]   shreg, shreg_next;
  logic [ADDR_W-1:0]   fetch_idx, fetch_idx_next;
  logic [BYTE_W-1:0]   rd_data;

  logic accept, busy, byte_end, zero_slot, wr_en;
  logic res_bit, res_valid, res_last, res_latch;
  logic [SLOT_W-1:0] slot_inc;

  // Store index of the byte sent in a given slot of the frame.
  function automatic logic [ADDR_W-1:0] slot_index(input logic [SLOT_W-1:0] slot,
                                                   input logic ctrl);
    logic [SLOT_W-1:0] diff;
    diff = TOP_SLOT - slot;
    if (slot >= END_SLOT) begin
      return '0;
    end else if (ctrl && slot == '0) begin
      return HALF_TOP;
    end else begin
      return ADDR_W'(diff);
    end
  endfunction

  assign in_ready = !out_valid || out_ready;
  assign accept   = in_valid && in_ready;
  assign busy     = sending || latch_pending;
  // The flag bit and the last bit of every byte except the final one are followed by a fresh byte.
  assign byte_end  = (pos[2:0] == 3'd0) && (pos != LAST_POS);
  assign zero_slot = frame_is_control && (next_slot != '0) && (next_slot <= HALF_SLOT);
  assign slot_inc  = next_slot + 1'b1;
  assign wr_en     = accept && (kind == KIND_LOAD) && !busy
                     && ({1'b0, byte_index} < INDEX_END);

  ldfs_store #(
    .FRAME_BYTES(FRAME_BYTES),
    .ADDR_W     (ADDR_W)
  ) u_store (
    .clk    (clk),
    .wr_en  (wr_en),
    .wr_addr(ADDR_W'(byte_index)),
    .wr_data(byte_value),
    .rd_addr(fetch_idx_next),
    .rd_data(rd_data)
  );

  always_comb begin
    sending_next          = sending;
    latch_pending_next    = latch_pending;
    frame_is_control_next = frame_is_control;
    pos_next              = pos;
    next_slot_next        = next_slot;
    shreg_next            = shreg;
    fetch_idx_next        = fetch_idx;
    res_bit               = 1'b0;
    res_valid             = 1'b0;
    res_last              = 1'b0;
    res_latch             = 1'b0;
    if (accept) begin
      unique case (kind)
        KIND_LOAD: begin
        end
        KIND_START: begin
          if (!busy) begin
            sending_next          = 1'b1;
            pos_next              = '0;
            frame_is_control_next = control_frame;
            next_slot_next        = '0;
            fetch_idx_next        = slot_index('0, control_frame);
          end
        end
        KIND_TICK: begin
          if (sending) begin
            res_bit   = (pos == '0) ? frame_is_control : shreg[BYTE_W-1];
            res_valid = 1'b1;
            if (pos == LAST_POS) begin
              res_last           = 1'b1;
              sending_next       = 1'b0;
              latch_pending_next = 1'b1;
              pos_next           = '0;
            end else begin
              pos_next = pos + 1'b1;
            end
            if (byte_end) begin
              shreg_next     = zero_slot ? '0 : rd_data;
              next_slot_next = slot_inc;
              fetch_idx_next = slot_index(slot_inc, frame_is_control);
            end else begin
              shreg_next = {shreg[BYTE_W-2:0], 1'b0};
            end
          end else if (latch_pending) begin
            res_latch          = 1'b1;
            latch_pending_next = 1'b0;
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      sending          <= 1'b0;
      latch_pending    <= 1'b0;
      frame_is_control <= 1'b0;
      pos              <= '0;
      next_slot        <= '0;
      out_valid        <= 1'b0;
    end else begin
      sending          <= sending_next;
      latch_pending    <= latch_pending_next;
      frame_is_control <= frame_is_control_next;
      pos              <= pos_next;
      next_slot        <= next_slot_next;
      if (in_ready) begin
        out_valid <= in_valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    shreg     <= shreg_next;
    fetch_idx <= fetch_idx_next;
    if (accept) begin
      serial_bit  <= res_bit;
      bit_valid   <= res_valid;
      last_bit    <= res_last;
      latch_pulse <= res_latch;
      busy_res    <= sending_next || latch_pending_next;
    end
  end

`ifndef NO_ASSERTIONS
  a_state_exclusive: assert property (@(posedge clk) disable iff (rst)
    !(sending && latch_pending))
    else $error("frame sending and latch pending at the same time");

  a_pos_range: assert property (@(posedge clk) disable iff (rst)
    sending |-> (pos <= LAST_POS))
    else $error("bit position ran past the end of the frame");

  a_last_then_latch: assert property (@(posedge clk) disable iff (rst)
    (accept && res_last) |=> (latch_pending && !sending))
    else $error("final bit did not arm the latch pulse");

  a_latch_word: assert property (@(posedge clk) disable iff (rst)
    (out_valid && latch_pulse) |-> (!bit_valid && !busy_res))
    else $error("latch word carries a data bit or reports busy");
`endif

endmodule

### hdl/ldfs_store.sv
// Frame byte store: one write port, one read port with registered read data.
// Depends on ldfs_pkg for the byte width.
module ldfs_store #(
  parameter int FRAME_BYTES = ldfs_pkg::FRAME_BYTES_DEF,
  parameter int ADDR_W      = $clog2(FRAME_BYTES)
) (
  input  logic                       clk,
  input  logic                       wr_en,
  input  logic [ADDR_W-1:0]          wr_addr,
  input  logic [ldfs_pkg::BYTE_W-1:0] wr_data,
  input  logic [ADDR_W-1:0]          rd_addr,
  output logic [ldfs_pkg::BYTE_W-1:0] rd_data
);
  import ldfs_pkg::*;

  logic [BYTE_W-1:0] mem [FRAME_BYTES];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

### sim/testbench.sv
`timescale 1ns / 1ps
// Testbench for led_driver_frame_serializer: a directed table, then whole PWM and control frames
// with random data and noise, checked word by word against a local bit-level predictor or, for
// typed table rows, a fixed idle word. Depends on ldfs_pkg and the RTL under hdl.
module testbench;
  import ldfs_pkg::*;

  localparam int STORE_BYTES = FRAME_BYTES_DEF;
  localparam int HALF_BYTES = STORE_BYTES / 2;
  localparam int LAST_POS = STORE_BYTES * 8;
  localparam logic [KIND_W-1:0] KIND_UNUSED = 2'd3;
  localparam int HOLD_CYCLES = 300;
  localparam int DRAIN_CYCLES = 20;
  localparam int LIMIT_CYCLES = 500000;
  localparam int SESSIONS = 3;
  localparam int PROBE_ROWS = 14;

  typedef struct packed {
    logic serial_bit;
    logic bit_valid;
    logic last_bit;
    logic latch_pulse;
    logic busy_res;
  } serial_res_t;

  typedef struct packed {
    logic [KIND_W-1:0]  kind;
    logic [INDEX_W-1:0] idx;
    logic [BYTE_W-1:0]  val;
    logic               ctrl;
    bit                 typed;
    serial_res_t        res;
  } probe_row_t;

  localparam serial_res_t IDLE_RES = '0;

  logic clk;
  logic rst;
  logic in_valid;
  logic in_ready;
  logic [KIND_W-1:0] kind;
  logic [INDEX_W-1:0] byte_index;
  logic [BYTE_W-1:0] byte_value;
  logic control_frame;
  logic out_valid;
  logic out_ready = 1'b0;
  logic serial_bit;
  logic bit_valid;
  logic last_bit;
  logic latch_pulse;
  logic busy_res;

  // Predictor state: a shadow of the frame store and the shift sequencer.
  logic [BYTE_W-1:0] store_copy [STORE_BYTES];
  bit store_written [STORE_BYTES];
  int frame_pos;
  bit frame_sending;
  bit latch_due;
  bit frame_ctrl;

  serial_res_t bits_due [$];
  int errors = 0;
  int cycles = 0;
  int hold_asks = 0;
  int rx_hold_left = 0;
  int tx_calm_left = 0;
  bit tail_phase = 1'b0;
  probe_row_t probe_rows [PROBE_ROWS];

  led_driver_frame_serializer uut (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .kind(kind),
    .byte_index(byte_index),
    .byte_value(byte_value),
    .control_frame(control_frame),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .serial_bit(serial_bit),
    .bit_valid(bit_valid),
    .last_bit(last_bit),
    .latch_pulse(latch_pulse),
    .busy_res(busy_res)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > LIMIT_CYCLES) begin
      $display("%0t timeout with %0d words outstanding", $time, bits_due.size());
      $display("RESULT: ERROR");
      $finish;
    end
  end

  function automatic serial_res_t predict_serial(input logic [KIND_W-1:0] k,
                                                 input logic [INDEX_W-1:0] idx,
                                                 input logic [BYTE_W-1:0] val,
                                                 input logic ctrl);
    serial_res_t r;
    int q;
    int slot;
    int src;
    bit busy;
    r = '0;
    busy = frame_sending || latch_due;
    case (k)
      KIND_LOAD: begin
        if (!busy && idx < STORE_BYTES) begin
          store_copy[idx] = val;
          store_written[idx] = 1'b1;
        end
      end
      KIND_START: begin
        if (!busy) begin
          frame_sending = 1'b1;
          frame_pos = 0;
          frame_ctrl = ctrl;
        end
      end
      KIND_TICK: begin
        if (frame_sending) begin
          if (frame_pos == 0) begin
            r.serial_bit = frame_ctrl;
          end else begin
            q = frame_pos - 1;
            slot = q >> 3;
            // A control frame sends byte HALF_BYTES-1 first, then a zero-filled gap, then the bytes below it.
            if (frame_ctrl && slot == 0) src = HALF_BYTES - 1;
            else if (frame_ctrl && slot <= HALF_BYTES) src = -1;
            else src = STORE_BYTES - 1 - slot;
            if (src >= 0) r.serial_bit = store_copy[src][7 - (q % 8)];
          end
          r.bit_valid = 1'b1;
          if (frame_pos >= LAST_POS) begin
            r.last_bit = 1'b1;
            frame_sending = 1'b0;
            latch_due = 1'b1;
            frame_pos = 0;
          end else begin
            frame_pos = frame_pos + 1;
          end
        end else if (latch_due) begin
          r.latch_pulse = 1'b1;
          latch_due = 1'b0;
        end
      end
      default: ;
    endcase
    r.busy_res = frame_sending || latch_due;
    return r;
  endfunction

  function automatic logic [BYTE_W-1:0] pick_byte();
    int r;
    r = $urandom_range(0, 99);
    if (r < 10) return 8'h00;
    if (r < 20) return 8'hff;
    return BYTE_W'($urandom_range(0, 255));
  endfunction

  function automatic logic [INDEX_W-1:0] any_index();
    return INDEX_W'($urandom_range(0, 127));
  endfunction

  function automatic logic [BYTE_W-1:0] any_byte();
    return BYTE_W'($urandom_range(0, 255));
  endfunction

  function automatic logic any_bit();
    return 1'($urandom_range(0, 1));
  endfunction

  // Offers one word, waits for it to be taken, then records what must come back for it.
  task automatic offer_word(input logic [KIND_W-1:0] k, input logic [INDEX_W-1:0] idx,
                            input logic [BYTE_W-1:0] val, input logic ctrl,
                            input bit typed, input serial_res_t typed_res);
    serial_res_t predicted;
    kind <= k;
    byte_index <= idx;
    byte_value <= val;
    control_frame <= ctrl;
    in_valid <= 1'b1;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    predicted = predict_serial(k, idx, val, ctrl);
    bits_due.push_back(typed ? typed_res : predicted);
    if (tail_phase || rx_hold_left > 0) return;
    if (tx_calm_left > 0) begin
      tx_calm_left--;
    end else if ($urandom_range(0, 99) < 3) begin
      tx_calm_left = $urandom_range(20, 80);
    end else if ($urandom_range(0, 99) < 15) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 10)) @(posedge clk);
    end
  endtask

  // Words that never move the sequencer forward; while a frame runs, loads and starts are
  // among them since the block must drop them.
  task automatic offer_noise(input bit frame_running);
    case ($urandom_range(0, 2))
      0: offer_word(KIND_UNUSED, any_index(), any_byte(), any_bit(), 1'b0, IDLE_RES);
      1: begin
        if (frame_running)
          offer_word(KIND_LOAD, any_index(), any_byte(), any_bit(), 1'b0, IDLE_RES);
        else
          offer_word(KIND_LOAD, INDEX_W'($urandom_range(STORE_BYTES, 127)), any_byte(),
                     any_bit(), 1'b0, IDLE_RES);
      end
      default: begin
        if (frame_running)
          offer_word(KIND_START, any_index(), any_byte(), any_bit(), 1'b0, IDLE_RES);
        else
          offer_word(KIND_TICK, any_index(), any_byte(), any_bit(), 1'b0, IDLE_RES);
      end
    endcase
  endtask

  task automatic check_field(input string name, input logic exp_v, input logic act_v);
    if (act_v !== exp_v) begin
      errors++;
      $display("%0t mismatch on %s: expected %0b actual %0b", $time, name, exp_v, act_v);
    end
  endtask

  always @(posedge clk) begin
    serial_res_t want;
    if (!rst && out_valid && out_ready) begin
      if (bits_due.size() == 0) begin
        errors++;
        $display("%0t unexpected word: expected none actual %b%b%b%b%b", $time,
                 serial_bit, bit_valid, last_bit, latch_pulse, busy_res);
      end else begin
        want = bits_due.pop_front();
        check_field("serial_bit", want.serial_bit, serial_bit);
        check_field("bit_valid", want.bit_valid, bit_valid);
        check_field("last_bit", want.last_bit, last_bit);
        check_field("latch_pulse", want.latch_pulse, latch_pulse);
        check_field("busy_res", want.busy_res, busy_res);
      end
    end
  end

  // Receiver pacing: random stall bursts, calm stretches, and one long hold on request.
  always @(posedge clk) begin
    int r;
    int stall_left;
    int calm_left;
    int hold_seen;
    if (hold_seen != hold_asks) begin
      hold_seen = hold_asks;
      rx_hold_left = HOLD_CYCLES;
    end
    if (rx_hold_left > 0) begin
      rx_hold_left--;
      out_ready <= 1'b0;
    end else if (tail_phase) begin
      out_ready <= 1'b1;
    end else if (stall_left > 0) begin
      stall_left--;
      out_ready <= 1'b0;
    end else if (calm_left > 0) begin
      calm_left--;
      out_ready <= 1'b1;
    end else begin
      r = $urandom_range(0, 99);
      if (r < 12) begin
        stall_left = $urandom_range(1, 10) - 1;
        out_ready <= 1'b0;
      end else begin
        if (r < 15) calm_left = $urandom_range(30, 100);
        out_ready <= 1'b1;
      end
    end
  end

  initial begin
    int session;
    int idx;
    int extra;
    bit descend;
    bit hold_done;
    logic ctrl_pick;
    rst <= 1'b1;
    in_valid <= 1'b0;
    kind <= KIND_TICK;
    byte_index <= '0;
    byte_value <= '0;
    control_frame <= 1'b0;
    hold_done = 1'b0;
    frame_pos = 0;
    frame_sending = 1'b0;
    latch_due = 1'b0;
    frame_ctrl = 1'b0;
    foreach (store_written[n]) begin
      store_written[n] = 1'b0;
      store_copy[n] = '0;
    end

    probe_rows = '{
      '{KIND_TICK,   7'd0,   8'h00, 1'b0, 1'b1, IDLE_RES},
      '{KIND_UNUSED, 7'd127, 8'hff, 1'b1, 1'b1, IDLE_RES},
      '{KIND_LOAD,   7'd96,  8'hff, 1'b1, 1'b1, IDLE_RES},
      '{KIND_LOAD,   7'd127, 8'ha5, 1'b0, 1'b1, IDLE_RES},
      '{KIND_TICK,   7'd127, 8'hff, 1'b1, 1'b1, IDLE_RES},
      '{KIND_LOAD,   7'd0,   8'hff, 1'b0, 1'b0, IDLE_RES},
      '{KIND_LOAD,   7'd95,  8'h00, 1'b1, 1'b0, IDLE_RES},
      '{KIND_LOAD,   7'd47,  8'h80, 1'b0, 1'b0, IDLE_RES},
      '{KIND_LOAD,   7'd46,  8'h01, 1'b0, 1'b0, IDLE_RES},
      '{KIND_LOAD,   7'd48,  8'h7f, 1'b0, 1'b0, IDLE_RES},
      '{KIND_LOAD,   7'd64,  8'h55, 1'b1, 1'b0, IDLE_RES},
      '{KIND_UNUSED, 7'd0,   8'h00, 1'b0, 1'b1, IDLE_RES},
      '{KIND_LOAD,   7'd0,   8'h00, 1'b0, 1'b0, IDLE_RES},
      '{KIND_LOAD,   7'd0,   8'hff, 1'b1, 1'b0, IDLE_RES}
    };

    repeat (4) @(posedge clk);
    rst <= 1'b0;

    for (int i = 0; i < PROBE_ROWS; i++) begin
      offer_word(probe_rows[i].kind, probe_rows[i].idx, probe_rows[i].val, probe_rows[i].ctrl,
                 probe_rows[i].typed, probe_rows[i].res);
    end

    for (session = 0; session < SESSIONS; session++) begin
      if (session == 1) begin
        // Let the pipeline run dry before the next frame is set up.
        in_valid <= 1'b0;
        while (bits_due.size() != 0) @(posedge clk);
      end

      // Fill every byte not yet written and refresh some of the rest.
      descend = any_bit();
      for (int n = 0; n < STORE_BYTES; n++) begin
        idx = descend ? STORE_BYTES - 1 - n : n;
        if ($urandom_range(0, 9) == 0) offer_noise(1'b0);
        if (!store_written[idx] || $urandom_range(0, 3) == 0)
          offer_word(KIND_LOAD, INDEX_W'(idx), pick_byte(), any_bit(), 1'b0, IDLE_RES);
      end
      extra = $urandom_range(0, 10);
      repeat (extra) begin
        offer_word(KIND_LOAD, INDEX_W'($urandom_range(0, STORE_BYTES - 1)), pick_byte(),
                   any_bit(), 1'b0, IDLE_RES);
      end

      if (session == 0) ctrl_pick = 1'b0;
      else if (session == 1) ctrl_pick = 1'b1;
      else ctrl_pick = any_bit();
      offer_word(KIND_START, any_index(), any_byte(), ctrl_pick, 1'b0, IDLE_RES);

      while (frame_sending || latch_due) begin
        if (session == 0 && frame_pos >= 100 && !hold_done) begin
          hold_done = 1'b1;
          hold_asks++;
        end
        if (session == SESSIONS - 1 && frame_pos >= LAST_POS / 2) tail_phase = 1'b1;
        if ($urandom_range(0, 99) < 90)
          offer_word(KIND_TICK, any_index(), any_byte(), any_bit(), 1'b0, IDLE_RES);
        else
          offer_noise(1'b1);
      end

      repeat ($urandom_range(0, 3)) begin
        offer_word(KIND_TICK, any_index(), any_byte(), any_bit(), 1'b0, IDLE_RES);
      end
    end

    in_valid <= 1'b0;
    while (bits_due.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (errors == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
